// ----- rtl/core/mprc_pkg.sv -----
// ----------------------------------------------------------------------------
// mprc_pkg
// Shared types and constants of the memory protection region checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mprc_pkg;

  localparam int MAX_REGIONS = 32;
  localparam int ADDR_W      = 20;
  localparam int LIMIT_W     = 21;
  localparam int DATA_W      = 16;
  localparam int NREG_W      = 6;
  localparam int RIDX_W      = 8;
  localparam int FAULT_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 21;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REQ_WORD_WRITE = 2'd0,
    REQ_BYTE_WRITE = 2'd1,
    REQ_LOCK       = 2'd2,
    REQ_UNLOCK     = 2'd3
  } mprc_req_type_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_DISABLED  = 2'd1,
    ERR_BAD_INDEX = 2'd2
  } mprc_req_err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED      = 3'd0,
    CFG_REGION_BASE  = 3'd1,
    CFG_REGION_LIMIT = 3'd2,
    CFG_NUM_REGIONS  = 3'd3,
    CFG_CODE_BASE    = 3'd4,
    CFG_CODE_LIMIT   = 3'd5
  } mprc_cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SIZE,
    BK_RANGE,
    BK_BLOCK,
    BK_DONE
  } mprc_back_state_e;

  typedef struct packed {
    logic               enabled;
    logic [ADDR_W-1:0]  region_base;
    logic [LIMIT_W-1:0] region_limit;
    logic [NREG_W-1:0]  eff_regions;
    logic [ADDR_W-1:0]  code_base;
    logic [LIMIT_W-1:0] code_limit;
  } mprc_cfg_t;

  typedef struct packed {
    logic flush_size;
    logic clear_locks;
  } mprc_cfg_evt_t;

  typedef struct packed {
    logic              is_write;
    logic              is_byte;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              code_write;
    logic              check;
    logic [ADDR_W-1:0] offset;
    mprc_req_err_e     req_error;
    logic              lock_do;
    logic              lock_set;
    logic [RIDX_W-1:0] lock_index;
  } mprc_item_t;

  typedef struct packed {
    logic               valid;
    mprc_item_t         item;
  } mprc_queue_out_t;

  typedef struct packed {
    logic               fwd_valid;
    logic               fwd_is_byte;
    logic [ADDR_W-1:0]  fwd_address;
    logic [DATA_W-1:0]  fwd_data;
    logic               fault;
    logic [FAULT_W-1:0] fault_region;
    logic               code_write;
    mprc_req_err_e      req_error;
  } mprc_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/mprc_front.sv -----
// ----------------------------------------------------------------------------
// mprc_front
// Classifies each request: write range checks, code area flag, lock errors.
// ----------------------------------------------------------------------------
`default_nettype none

module mprc_front import mprc_pkg::*; (
  input  wire mprc_cfg_t         cfg_i,
  input  wire [1:0]              req_type_i,
  input  wire [ADDR_W-1:0]       address_i,
  input  wire [DATA_W-1:0]       write_data_i,
  input  wire [RIDX_W-1:0]       region_index_i,
  output mprc_item_t             item_o
);

  mprc_req_type_e req_type;
  logic           is_write;
  logic           in_prot;
  logic           in_code;

  assign req_type = mprc_req_type_e'(req_type_i);

  always_comb begin
    is_write = 1'b0;
    item_o   = '0;
    unique case (req_type)
      REQ_WORD_WRITE: begin
        is_write = 1'b1;
      end
      REQ_BYTE_WRITE: begin
        is_write = 1'b1;
      end
      REQ_LOCK: begin
        is_write = 1'b0;
      end
      REQ_UNLOCK: begin
        is_write = 1'b0;
      end
    endcase

    in_prot = (address_i >= cfg_i.region_base) &&
              ({1'b0, address_i} < cfg_i.region_limit);
    in_code = (address_i >= cfg_i.code_base) &&
              ({1'b0, address_i} < cfg_i.code_limit);

    item_o.req_error  = ERR_OK;
    item_o.lock_index = region_index_i;
    item_o.lock_set   = (req_type == REQ_LOCK);
    if (is_write) begin
      item_o.is_write   = 1'b1;
      item_o.is_byte    = (req_type == REQ_BYTE_WRITE);
      item_o.address    = address_i;
      item_o.data       = (req_type == REQ_BYTE_WRITE) ?
                          {{(DATA_W-8){1'b0}}, write_data_i[7:0]} : write_data_i;
      item_o.code_write = in_code;
      item_o.check      = cfg_i.enabled && (cfg_i.eff_regions != '0) && in_prot;
      item_o.offset     = address_i - cfg_i.region_base;
    end else if (!cfg_i.enabled) begin
      item_o.req_error = ERR_DISABLED;
    end else if (region_index_i >= RIDX_W'(cfg_i.eff_regions)) begin
      item_o.req_error = ERR_BAD_INDEX;
    end else begin
      item_o.lock_do = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mprc_queue.sv -----
// ----------------------------------------------------------------------------
// mprc_queue
// Short first-in first-out queue between the classifier and the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module mprc_queue import mprc_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  wire mprc_item_t        item_i,
  output logic                   full_o,
  input  wire                    pop_i,
  output mprc_queue_out_t        head_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mprc_item_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mprc_back.sv -----
// ----------------------------------------------------------------------------
// mprc_back
// Region lookup by iterative division, lock bits and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mprc_back import mprc_pkg::*; #(
  parameter int MaxRegions = MAX_REGIONS
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire mprc_cfg_t         cfg_i,
  input  wire mprc_cfg_evt_t     cfg_evt_i,
  input  wire mprc_queue_out_t   head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output mprc_result_t           result_o
);

  localparam int RW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int DW = ADDR_W + RW;
  localparam int CW = 5;

  mprc_back_state_e    state_q, state_d;
  mprc_item_t          item_q, item_d;
  logic [LIMIT_W-1:0]  sdiv_q, sdiv_d;
  logic [NREG_W-1:0]   srem_q, srem_d;
  logic [LIMIT_W-1:0]  bsize_q, bsize_d;
  logic                bsize_ok_q, bsize_ok_d;
  logic [ADDR_W-1:0]   rem_q, rem_d;
  logic [DW-1:0]       dsh_q, dsh_d;
  logic [RW-1:0]       quot_q, quot_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                blk_ok_q, blk_ok_d;
  logic                out_valid_q;
  mprc_result_t        result_q;
  logic [MaxRegions-1:0] locked_q;

  logic                res_load;
  logic [NREG_W:0]     t_size;
  logic                size_ge;
  logic                blk_ge;
  logic                over;
  logic                hit;
  mprc_result_t        result_d;

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    sdiv_d     = sdiv_q;
    srem_d     = srem_q;
    bsize_d    = bsize_q;
    bsize_ok_d = bsize_ok_q;
    rem_d      = rem_q;
    dsh_d      = dsh_q;
    quot_d     = quot_q;
    cnt_d      = cnt_q;
    blk_ok_d   = blk_ok_q;
    pop_o      = 1'b0;
    res_load   = 1'b0;

    t_size  = {srem_q, sdiv_q[LIMIT_W-1]};
    size_ge = (t_size >= {1'b0, cfg_i.eff_regions});
    blk_ge  = (DW'(rem_q) >= dsh_q);
    over    = (bsize_q == '0) ||
              ((LIMIT_W+RW)'(item_q.offset) >= {bsize_q, {RW{1'b0}}});

    unique case (state_q)
      BK_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          item_d   = head_i.item;
          blk_ok_d = 1'b0;
          if (!head_i.item.check) begin
            state_d = BK_DONE;
          end else if (bsize_ok_q) begin
            state_d = BK_RANGE;
          end else begin
            sdiv_d  = cfg_i.region_limit - {1'b0, cfg_i.region_base};
            srem_d  = '0;
            cnt_d   = CW'(LIMIT_W - 1);
            state_d = BK_SIZE;
          end
        end
      end
      BK_SIZE: begin
        srem_d = size_ge ? NREG_W'(t_size - {1'b0, cfg_i.eff_regions})
                         : t_size[NREG_W-1:0];
        sdiv_d = {sdiv_q[LIMIT_W-2:0], size_ge};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          bsize_d    = sdiv_d;
          bsize_ok_d = 1'b1;
          state_d    = BK_RANGE;
        end
      end
      BK_RANGE: begin
        rem_d    = item_q.offset;
        dsh_d    = DW'(bsize_q) << (RW - 1);
        quot_d   = '0;
        cnt_d    = CW'(RW - 1);
        blk_ok_d = !over;
        state_d  = over ? BK_DONE : BK_BLOCK;
      end
      BK_BLOCK: begin
        if (blk_ge) begin
          rem_d = rem_q - ADDR_W'(dsh_q);
        end
        quot_d = (quot_q << 1) | RW'(blk_ge);
        dsh_d  = dsh_q >> 1;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          res_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (cfg_evt_i.flush_size) begin
      bsize_ok_d = 1'b0;
    end
  end

  // region hit from the quotient of the block divider
  assign hit = item_q.check && blk_ok_q &&
               (9'(quot_q) < 9'(cfg_i.eff_regions)) && locked_q[quot_q];

  always_comb begin
    result_d              = '0;
    result_d.fwd_valid    = item_q.is_write;
    result_d.fwd_is_byte  = item_q.is_byte;
    result_d.fwd_address  = item_q.address;
    result_d.fwd_data     = item_q.data;
    result_d.code_write   = item_q.code_write;
    result_d.req_error    = item_q.req_error;
    result_d.fault        = hit;
    result_d.fault_region = hit ? FAULT_W'(quot_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      bsize_ok_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      bsize_ok_q <= bsize_ok_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    sdiv_q   <= sdiv_d;
    srem_q   <= srem_d;
    bsize_q  <= bsize_d;
    rem_q    <= rem_d;
    dsh_q    <= dsh_d;
    quot_q   <= quot_d;
    cnt_q    <= cnt_d;
    blk_ok_q <= blk_ok_d;
    if (res_load) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= '0;
    end else if (cfg_evt_i.clear_locks) begin
      locked_q <= '0;
    end else if (res_load && item_q.lock_do) begin
      locked_q[item_q.lock_index[RW-1:0]] <= item_q.lock_set;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ----- rtl/core/memory_protection_region_checker.sv -----
// ----------------------------------------------------------------------------
// memory_protection_region_checker
// Region lock checker for memory writes, with lock and unlock requests.
// ----------------------------------------------------------------------------
// The classifier takes one request per cycle while its two-word queue has
// room; the checker behind it retires words in order. A lock, unlock or
// unchecked write goes from the idle state straight to the done state. A
// checked write (unit enabled, regions configured, address inside the
// protected range) passes through a range state and the one-bit-per-cycle
// block divider before the done state, or from the range state straight to
// done when the block size is zero or the offset lies past the divider's
// last block. The first checked write after a change of region_base,
// region_limit or num_regions first recomputes the block size in a 21-step
// serial divider. Every word yields exactly one result word, held in an
// output register until taken. Writing num_regions clears all region locks.
`default_nettype none

module memory_protection_region_checker import mprc_pkg::*; #(
  parameter int MaxRegions = MAX_REGIONS
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire [1:0]              req_type_i,
  input  wire [ADDR_W-1:0]       address_i,
  input  wire [DATA_W-1:0]       write_data_i,
  input  wire [RIDX_W-1:0]       region_index_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic                   fwd_valid_o,
  output logic                   fwd_is_byte_o,
  output logic [ADDR_W-1:0]      fwd_address_o,
  output logic [DATA_W-1:0]      fwd_data_o,
  output logic                   fault_o,
  output logic [FAULT_W-1:0]     fault_region_o,
  output logic                   code_write_o,
  output logic [1:0]             request_error_o
);

  logic               enabled_q;
  logic [ADDR_W-1:0]  region_base_q;
  logic [LIMIT_W-1:0] region_limit_q;
  logic [NREG_W-1:0]  num_regions_q;
  logic [ADDR_W-1:0]  code_base_q;
  logic [LIMIT_W-1:0] code_limit_q;

  mprc_cfg_t          cfg;
  mprc_cfg_evt_t      cfg_evt;
  mprc_cfg_idx_e      cfg_idx;
  mprc_item_t         front_item;
  mprc_queue_out_t    head;
  logic               queue_full;
  logic               pop;
  mprc_result_t       result;

  assign cfg_idx = mprc_cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      region_base_q  <= '0;
      region_limit_q <= '0;
      num_regions_q  <= NREG_W'(1);
      code_base_q    <= '0;
      code_limit_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_ENABLED:      enabled_q      <= cfg_wdata_i[0];
        CFG_REGION_BASE:  region_base_q  <= cfg_wdata_i[ADDR_W-1:0];
        CFG_REGION_LIMIT: region_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_NUM_REGIONS:  num_regions_q  <= cfg_wdata_i[NREG_W-1:0];
        CFG_CODE_BASE:    code_base_q    <= cfg_wdata_i[ADDR_W-1:0];
        CFG_CODE_LIMIT:   code_limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_evt.flush_size  = cfg_we_i && ((cfg_idx == CFG_REGION_BASE) ||
                                       (cfg_idx == CFG_REGION_LIMIT) ||
                                       (cfg_idx == CFG_NUM_REGIONS));
    cfg_evt.clear_locks = cfg_we_i && (cfg_idx == CFG_NUM_REGIONS);
  end

  always_comb begin
    cfg.enabled      = enabled_q;
    cfg.region_base  = region_base_q;
    cfg.region_limit = region_limit_q;
    cfg.eff_regions  = (9'(num_regions_q) > 9'(MaxRegions)) ?
                       NREG_W'(MaxRegions) : num_regions_q;
    cfg.code_base    = code_base_q;
    cfg.code_limit   = code_limit_q;
  end

  mprc_front u_front (
    .cfg_i          (cfg),
    .req_type_i     (req_type_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .region_index_i (region_index_i),
    .item_o         (front_item)
  );

  assign in_ready_o = !queue_full;

  mprc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .item_i (front_item),
    .full_o (queue_full),
    .pop_i  (pop),
    .head_o (head)
  );

  mprc_back #(
    .MaxRegions (MaxRegions)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_evt_i   (cfg_evt),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign fwd_valid_o     = result.fwd_valid;
  assign fwd_is_byte_o   = result.fwd_is_byte;
  assign fwd_address_o   = result.fwd_address;
  assign fwd_data_o      = result.fwd_data;
  assign fault_o         = result.fault;
  assign fault_region_o  = result.fault_region;
  assign code_write_o    = result.code_write;
  assign request_error_o = result.req_error;

  // a fault only ever comes from a forwarded write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> fwd_valid_o)
    else $error("fault on a word that is not a write");

  // lock requests never forward, writes never report a request error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (request_error_o != ERR_OK) |-> !fwd_valid_o)
    else $error("request error on a forwarded write");

  // faults need the unit enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> enabled_q)
    else $error("fault while unit disabled");

  // fault region stays inside the configured region count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> (6'(fault_region_o) < cfg.eff_regions))
    else $error("fault region beyond region count");

endmodule

`default_nettype wire

// ----- bench/mprc_outcome_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mprc_outcome_checker
// Watches the configuration port and both word channels of the region
// checker. Keeps its own copy of the registers and lock bits, works out the
// result of every accepted request word and compares each result word, in
// order, field by field. Failures, pending words and a few totals go out to
// the bench top.
// ----------------------------------------------------------------------------
module mprc_outcome_checker import mprc_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                  in_valid_i,
  input  wire                  in_ready_i,
  input  wire [1:0]            req_type_i,
  input  wire [ADDR_W-1:0]     address_i,
  input  wire [DATA_W-1:0]     write_data_i,
  input  wire [RIDX_W-1:0]     region_index_i,
  input  wire                  out_valid_i,
  input  wire                  out_ready_i,
  input  wire                  fwd_valid_i,
  input  wire                  fwd_is_byte_i,
  input  wire [ADDR_W-1:0]     fwd_address_i,
  input  wire [DATA_W-1:0]     fwd_data_i,
  input  wire                  fault_i,
  input  wire [FAULT_W-1:0]    fault_region_i,
  input  wire                  code_write_i,
  input  wire [1:0]            request_error_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          faults_o,
  output int unsigned          rejects_o
);

  logic                   unit_on;
  logic [ADDR_W-1:0]      prot_base;
  logic [LIMIT_W-1:0]     prot_limit;
  logic [NREG_W-1:0]      region_count;
  logic [ADDR_W-1:0]      code_lo;
  logic [LIMIT_W-1:0]     code_hi;
  logic [MAX_REGIONS-1:0] lock_bits;
  mprc_result_t           awaited_results[$];
  int unsigned            fail_n;
  int unsigned            checked_n;
  int unsigned            fault_n;
  int unsigned            reject_n;

  function automatic mprc_result_t protect_outcome(mprc_req_type_e kind,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic [DATA_W-1:0] data,
                                                   logic [RIDX_W-1:0] ridx);
    mprc_result_t r;
    int unsigned  live;
    int unsigned  a;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  bsize;
    int unsigned  blk;
    r           = '0;
    r.req_error = ERR_OK;
    live = (region_count > MAX_REGIONS) ? MAX_REGIONS : region_count;
    if (kind == REQ_LOCK || kind == REQ_UNLOCK) begin
      if (!unit_on) begin
        r.req_error = ERR_DISABLED;
      end else if (ridx >= live) begin
        r.req_error = ERR_BAD_INDEX;
      end else begin
        lock_bits[ridx] = (kind == REQ_LOCK);
      end
      return r;
    end
    a  = addr;
    lo = prot_base;
    hi = prot_limit;
    r.fwd_valid   = 1'b1;
    r.fwd_is_byte = (kind == REQ_BYTE_WRITE);
    r.fwd_address = addr;
    r.fwd_data    = (kind == REQ_BYTE_WRITE) ? {8'h00, data[7:0]} : data;
    r.code_write  = (a >= int'(code_lo)) && (a < int'(code_hi));
    if (unit_on && live != 0 && hi > lo && a >= lo && a < hi) begin
      bsize = (hi - lo) / live;
      if (bsize != 0) begin
        blk = (a - lo) / bsize;
        if (blk < live && lock_bits[blk]) begin
          r.fault        = 1'b1;
          r.fault_region = blk[FAULT_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mprc_result_t want;
    mprc_result_t got;
    int           bad;
    if (!rst_ni) begin
      unit_on      = 1'b0;
      prot_base    = '0;
      prot_limit   = '0;
      region_count = NREG_W'(1);
      code_lo      = '0;
      code_hi      = '0;
      lock_bits    = '0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.fwd_valid    = fwd_valid_i;
        got.fwd_is_byte  = fwd_is_byte_i;
        got.fwd_address  = fwd_address_i;
        got.fwd_data     = fwd_data_i;
        got.fault        = fault_i;
        got.fault_region = fault_region_i;
        got.code_write   = code_write_i;
        got.req_error    = mprc_req_err_e'(request_error_i);
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with no request outstanding", $time);
          fail_n++;
        end else begin
          want = awaited_results.pop_front();
          bad  = 0;
          bad += field_mismatch("fwd_valid", want.fwd_valid, got.fwd_valid);
          bad += field_mismatch("fwd_is_byte", want.fwd_is_byte, got.fwd_is_byte);
          bad += field_mismatch("fwd_address", want.fwd_address, got.fwd_address);
          bad += field_mismatch("fwd_data", want.fwd_data, got.fwd_data);
          bad += field_mismatch("fault", want.fault, got.fault);
          bad += field_mismatch("fault_region", want.fault_region, got.fault_region);
          bad += field_mismatch("code_write", want.code_write, got.code_write);
          bad += field_mismatch("request_error", want.req_error, request_error_i);
          if (bad != 0) begin
            fail_n++;
          end
          checked_n++;
          if (want.fault) begin
            fault_n++;
          end
          if (want.req_error != ERR_OK) begin
            reject_n++;
          end
        end
      end
      if (cfg_we_i) begin
        case (mprc_cfg_idx_e'(cfg_index_i))
          CFG_ENABLED:      unit_on    = cfg_wdata_i[0];
          CFG_REGION_BASE:  prot_base  = cfg_wdata_i[ADDR_W-1:0];
          CFG_REGION_LIMIT: prot_limit = cfg_wdata_i[LIMIT_W-1:0];
          CFG_NUM_REGIONS: begin
            region_count = cfg_wdata_i[NREG_W-1:0];
            lock_bits    = '0;
          end
          CFG_CODE_BASE:    code_lo    = cfg_wdata_i[ADDR_W-1:0];
          CFG_CODE_LIMIT:   code_hi    = cfg_wdata_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(protect_outcome(mprc_req_type_e'(req_type_i), address_i,
                                                  write_data_i, region_index_i));
      end
    end
    fail_count_o <= fail_n;
    pending_o    <= awaited_results.size();
    checked_o    <= checked_n;
    faults_o     <= fault_n;
    rejects_o    <= reject_n;
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the region checker with lock, unlock and write requests under a
// series of register setups: a directed pass over the corner cases, then
// random words aimed mostly at the protected range. Both channels stall at
// random outside the two steady phases; the checker module beside the block judges every result word.
// ----------------------------------------------------------------------------
module testbench;
  import mprc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 14;
  localparam int          PHASE_ITEMS = 100;
  localparam int          SETTLE      = 4;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic [1:0]            req_type     = '0;
  logic [ADDR_W-1:0]     address      = '0;
  logic [DATA_W-1:0]     write_data   = '0;
  logic [RIDX_W-1:0]     region_index = '0;
  logic                  out_ready    = 1'b0;
  logic                  steady       = 1'b0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  fwd_valid_o;
  logic                  fwd_is_byte_o;
  logic [ADDR_W-1:0]     fwd_address_o;
  logic [DATA_W-1:0]     fwd_data_o;
  logic                  fault_o;
  logic [FAULT_W-1:0]    fault_region_o;
  logic                  code_write_o;
  logic [1:0]            request_error_o;

  int unsigned           fails;
  int unsigned           pending;
  int unsigned           checked;
  int unsigned           faults;
  int unsigned           rejects;
  int unsigned           cycles = 0;
  int unsigned           n_setups = 0;

  bit                    s_en;
  int unsigned           s_base;
  int unsigned           s_limit;
  int unsigned           s_nreg = 1;
  int unsigned           s_cbase;
  int unsigned           s_climit;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  memory_protection_region_checker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type),
    .address_i      (address),
    .write_data_i   (write_data),
    .region_index_i (region_index),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .fwd_valid_o    (fwd_valid_o),
    .fwd_is_byte_o  (fwd_is_byte_o),
    .fwd_address_o  (fwd_address_o),
    .fwd_data_o     (fwd_data_o),
    .fault_o        (fault_o),
    .fault_region_o (fault_region_o),
    .code_write_o   (code_write_o),
    .request_error_o(request_error_o)
  );

  mprc_outcome_checker outcome_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready_o),
    .req_type_i     (req_type),
    .address_i      (address),
    .write_data_i   (write_data),
    .region_index_i (region_index),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready),
    .fwd_valid_i    (fwd_valid_o),
    .fwd_is_byte_i  (fwd_is_byte_o),
    .fwd_address_i  (fwd_address_o),
    .fwd_data_i     (fwd_data_o),
    .fault_i        (fault_o),
    .fault_region_i (fault_region_o),
    .code_write_i   (code_write_o),
    .request_error_i(request_error_o),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .checked_o      (checked),
    .faults_o       (faults),
    .rejects_o      (rejects)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("memory_protection_region_checker regression: fail");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  task automatic push(mprc_req_type_e kind, logic [ADDR_W-1:0] addr,
                      logic [DATA_W-1:0] data, logic [RIDX_W-1:0] ridx);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    address      <= addr;
    write_data   <= data;
    region_index <= ridx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(mprc_cfg_idx_e idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic setup(bit en, int unsigned base, int unsigned lim, int unsigned nreg,
                       int unsigned cb, int unsigned cl, bit recount);
    settle();
    s_en     = en;
    s_base   = base;
    s_limit  = lim;
    s_cbase  = cb;
    s_climit = cl;
    write_reg(CFG_ENABLED, en);
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_LIMIT, lim);
    if (recount) begin
      s_nreg = nreg;
      write_reg(CFG_NUM_REGIONS, nreg);
    end
    write_reg(CFG_CODE_BASE, cb);
    write_reg(CFG_CODE_LIMIT, cl);
    cfg_we <= 1'b0;
    n_setups++;
  endtask

  initial begin
    bit                en;
    bit                recount;
    int unsigned       base;
    int unsigned       lim;
    int unsigned       nreg;
    int unsigned       cb;
    int unsigned       cl;
    int unsigned       live;
    int unsigned       roll;
    mprc_req_type_e    kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [RIDX_W-1:0] ridx;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset setup: unit off, empty code area
    push(REQ_LOCK, 20'h00000, 16'h0000, 8'd0);
    push(REQ_UNLOCK, 20'hFFFFF, 16'hFFFF, 8'd255);
    push(REQ_WORD_WRITE, 20'h00000, 16'hFFFF, 8'd0);
    push(REQ_BYTE_WRITE, 20'hFFFFF, 16'hFFFF, 8'd255);

    // eight regions of 0x100 plus a five byte tail
    setup(1'b1, 20'h10000, 21'h10805, 8, 20'h04000, 21'h08000, 1'b1);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd0);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd7);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd8);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd255);
    push(REQ_WORD_WRITE, 20'h10000, 16'h1234, 8'd0);
    push(REQ_BYTE_WRITE, 20'h107FF, 16'hABCD, 8'd0);
    push(REQ_WORD_WRITE, 20'h10800, 16'h5555, 8'd0);
    push(REQ_WORD_WRITE, 20'h10805, 16'hAAAA, 8'd0);
    push(REQ_WORD_WRITE, 20'h0FFFF, 16'h0001, 8'd0);
    push(REQ_UNLOCK, 20'h0, 16'h0, 8'd0);
    push(REQ_WORD_WRITE, 20'h10000, 16'h8000, 8'd0);
    push(REQ_BYTE_WRITE, 20'h04000, 16'hFF00, 8'd0);
    push(REQ_WORD_WRITE, 20'h07FFF, 16'h7FFF, 8'd0);
    push(REQ_WORD_WRITE, 20'h08000, 16'h0000, 8'd0);

    // rewriting the region count drops every lock
    setup(1'b1, 20'h10000, 21'h10805, 8, 20'h04000, 21'h08000, 1'b1);
    push(REQ_WORD_WRITE, 20'h10700, 16'h0F0F, 8'd0);

    // range shorter than the region count
    setup(1'b1, 20'h00100, 21'h00104, 8, 20'h00000, 21'h100000, 1'b1);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd1);
    push(REQ_WORD_WRITE, 20'h00101, 16'h4242, 8'd0);

    // no regions at all
    setup(1'b1, 20'h00000, 21'h100000, 0, 20'h00000, 21'h00000, 1'b1);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd0);
    push(REQ_WORD_WRITE, 20'h00000, 16'h0000, 8'd0);

    // inverted ranges, oversized region count
    setup(1'b1, 20'hFFFFF, 21'h00010, 63, 20'h08000, 21'h04000, 1'b1);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd31);
    push(REQ_LOCK, 20'h0, 16'h0, 8'd32);
    push(REQ_WORD_WRITE, 20'hFFFFF, 16'hFFFF, 8'd0);

    for (int p = 0; p < PHASES; p++) begin
      en   = ($urandom_range(0, 9) != 0);
      base = $urandom_range(0, 20'hFFFFF);
      case ($urandom_range(0, 3))
        0:       lim = base + $urandom_range(0, 40);
        1:       lim = base + $urandom_range(0, 16'hFFFF);
        2:       lim = base + $urandom_range(0, 20'hFFFFF);
        default: lim = $urandom_range(0, 21'h1FFFFF);
      endcase
      nreg = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 32) : $urandom_range(0, 63);
      cb   = $urandom_range(0, 20'hFFFFF);
      cl   = ($urandom_range(0, 3) != 0) ? cb + $urandom_range(0, 18'h3FFFF)
                                         : $urandom_range(0, 21'h1FFFFF);
      recount = 1'($urandom_range(0, 1));
      case (p)
        0: begin
          en = 1'b1; base = 0; lim = 21'h100000; nreg = 32; recount = 1'b1;
        end
        1: begin
          en = 1'b1; lim = 21'h1FFFFF; nreg = 1; recount = 1'b1;
        end
        2: begin
          en = 1'b1; nreg = 63; recount = 1'b1;
        end
        3:       en = 1'b0;
        default: ;
      endcase
      if (lim > 21'h1FFFFF) lim = 21'h1FFFFF;
      if (cl > 21'h1FFFFF) cl = 21'h1FFFFF;
      setup(en, base, lim, nreg, cb, cl, recount);
      steady <= (p == 6 || p == 7);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        live = (s_nreg > MAX_REGIONS) ? MAX_REGIONS : s_nreg;
        addr = ADDR_W'($urandom_range(0, 20'hFFFFF));
        data = DATA_W'($urandom_range(0, 16'hFFFF));
        ridx = RIDX_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 30) begin
          kind = ($urandom_range(0, 2) != 0) ? REQ_LOCK : REQ_UNLOCK;
          if ($urandom_range(0, 9) != 0) ridx = RIDX_W'($urandom_range(0, live));
        end else begin
          kind = ($urandom_range(0, 1) != 0) ? REQ_BYTE_WRITE : REQ_WORD_WRITE;
          roll = $urandom_range(0, 99);
          if (roll < 60 && s_limit > s_base) begin
            addr = ADDR_W'($urandom_range(s_base,
                                          (s_limit > 21'h100000) ? 20'hFFFFF : s_limit - 1));
          end else if (roll < 75 && s_climit > s_cbase) begin
            addr = ADDR_W'($urandom_range(s_cbase,
                                          (s_climit > 21'h100000) ? 20'hFFFFF : s_climit - 1));
          end
        end
        push(kind, addr, data, ridx);
      end
    end

    settle();
    $display("checked %0d result words over %0d register setups", checked, n_setups);
    $display("%0d writes hit locked regions, %0d lock requests rejected", faults, rejects);
    if (fails == 0 && pending == 0) begin
      $display("memory_protection_region_checker regression: pass");
    end else begin
      $display("memory_protection_region_checker regression: fail");
    end
    $finish;
  end

endmodule
